// File: hdl/fspa_pkg.sv
package fspa_pkg;

  // Address arithmetic width; the pool wraps modulo 2^ADDR_W.
  localparam int ADDR_W = 32;

  // Field widths of the request and result beats.
  localparam int MODE_W      = 2;
  localparam int INDEX_W     = 6;
  localparam int STATUS_W    = 3;
  localparam int ELEM_W      = 16;
  localparam int COUNT_W     = 7;
  localparam int STRIDE_W    = ELEM_W + 1;

  // Bus widths, packed fields padded to whole bytes.
  localparam int IN_TDATA_W  = 40;
  localparam int IN_TUSER_W  = MODE_W;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_TUSER_W = STATUS_W;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  typedef logic [MODE_W-1:0]   mode_t;
  typedef logic [STATUS_W-1:0] status_t;

  // Request kinds.
  localparam mode_t MODE_ALLOC     = 2'd0;
  localparam mode_t MODE_FREE_ADDR = 2'd1;
  localparam mode_t MODE_FREE_IDX  = 2'd2;
  localparam mode_t MODE_GET_IDX   = 2'd3;

  // Result status codes.
  localparam status_t ST_OK         = 3'd0;
  localparam status_t ST_FULL       = 3'd1;
  localparam status_t ST_RANGE      = 3'd2;
  localparam status_t ST_MISALIGNED = 3'd3;
  localparam status_t ST_NOT_ALLOC  = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_BASE_ADDRESS  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ELEMENT_BYTES = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SLOT_COUNT    = 2'd2;

endpackage

// File: hdl/fixed_slot_pool_allocator.sv
// Fixed slot pool allocator: hands out and takes back equal slots of a pool.
// Requests arrive as beats on the in_ stream: in_tuser carries the request
// kind (allocate, free by address, free by index, get by index), in_tdata the
// element address and slot index. Each request yields exactly one result beat
// on the out_ stream: out_tuser carries the status, out_tdata the slot index
// and element address. The cfg_ port writes base address, element size and
// slot count; write it only while no request is in flight.
// One request is handled at a time; in_tready is high only while idle. Work
// goes through a single shared 32-bit add/subtract unit and an in-use memory
// with one write port and a registered read port; free by address takes 7
// division steps. A finished result sits in an output register; while the
// receiver stalls it holds there and the next request is already accepted
// and worked on up to its own result.
// After reset the in-use memory is cleared one entry per cycle, during which
// no request is accepted (configuration writes still are); configuration
// returns to base 0, element size 1, slot count 64.
module fixed_slot_pool_allocator #(
  parameter int MAX_SLOTS = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Request stream.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // tdata: element_address[31:0], slot_index_in[37:32], zero pad.
  input  logic [fspa_pkg::IN_TDATA_W-1:0]   in_tdata,
  // tuser: mode[1:0].
  input  logic [fspa_pkg::IN_TUSER_W-1:0]   in_tuser,
  // Result stream.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // tdata: slot_index[5:0], slot_address[37:6], zero pad.
  output logic [fspa_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // tuser: status[2:0].
  output logic [fspa_pkg::OUT_TUSER_W-1:0]  out_tuser,
  // Configuration write port.
  input  logic                              cfg_we,
  input  logic [fspa_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [fspa_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  import fspa_pkg::*;

  localparam int IW    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W = $clog2(MAX_SLOTS + 1);
  // Largest usable slot count as seen through the 7-bit register.
  localparam logic [COUNT_W:0] CAP = (MAX_SLOTS > 127) ? (COUNT_W + 1)'(127)
                                                        : (COUNT_W + 1)'(MAX_SLOTS);

  // Sequencer states.
  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_DEC  = 4'd2;
  localparam logic [3:0] S_SUB  = 4'd3;
  localparam logic [3:0] S_PRE  = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_FCHK = 4'd6;
  localparam logic [3:0] S_IDX  = 4'd7;
  localparam logic [3:0] S_LOOK = 4'd8;
  localparam logic [3:0] S_SCAN = 4'd9;
  localparam logic [3:0] S_MB   = 4'd10;
  localparam logic [3:0] S_ML   = 4'd11;
  localparam logic [3:0] S_OUT  = 4'd12;

  // Configuration registers.
  logic [ADDR_W-1:0]   base_r;
  logic [ELEM_W-1:0]   elem_r;
  logic [COUNT_W-1:0]  scount_r;

  // Sequencer and work registers.
  logic [3:0]          state_r, state_nxt;
  logic [ADDR_W-1:0]   rem_r, rem_nxt;
  logic [COUNT_W-1:0]  sel_idx_r, sel_idx_nxt;
  logic [COUNT_W-1:0]  scan_r, scan_nxt;
  logic [COUNT_W-1:0]  chk_idx_r, chk_idx_nxt;
  logic                chk_vld_r, chk_vld_nxt;
  logic [2:0]          k_r, k_nxt;
  mode_t               mode_r, mode_nxt;
  status_t             res_status_r, res_status_nxt;
  logic                addr_en_r, addr_en_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [IW-1:0]       clr_r, clr_nxt;

  // Output register.
  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [INDEX_W-1:0]  out_sidx_r, out_sidx_nxt;
  logic [ADDR_W-1:0]   out_addr_r, out_addr_nxt;

  // In-use memory.
  logic                mem [MAX_SLOTS];
  logic                rd_data_r;
  logic [IW-1:0]       rd_addr;
  logic                mem_we;
  logic [IW-1:0]       mem_wa;
  logic                mem_wd;

  // Shared add/subtract unit.
  logic [ADDR_W-1:0]   alu_a, alu_b;
  logic                alu_sub;
  logic [ADDR_W:0]     alu_sum;
  logic                alu_carry;
  logic [ADDR_W-1:0]   alu_res;

  logic [COUNT_W-1:0]  n_eff;
  logic [STRIDE_W-1:0] stride;
  logic [ADDR_W-1:0]   stride_k;
  logic [ADDR_W-1:0]   stride_7;
  logic                out_free;

  // Effective slot count and slot stride.
  assign n_eff    = ({1'b0, scount_r} > CAP) ? CAP[COUNT_W-1:0] : scount_r;
  assign stride   = {1'b0, elem_r} + STRIDE_W'(1);
  assign stride_k = ADDR_W'({{(ADDR_W - STRIDE_W){1'b0}}, stride} << k_r);
  assign stride_7 = ADDR_W'({{(ADDR_W - STRIDE_W){1'b0}}, stride} << 7);

  // The unit adds, or subtracts with carry meaning no borrow.
  assign alu_sum   = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                   + (ADDR_W + 1)'(alu_sub);
  assign alu_carry = alu_sum[ADDR_W];
  assign alu_res   = alu_sum[ADDR_W-1:0];

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{(OUT_TDATA_W - ADDR_W - INDEX_W){1'b0}}, out_addr_r, out_sidx_r};

  // Operand selection for the shared unit.
  always_comb begin
    alu_a   = rem_r;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_r)
      S_DEC: begin
        alu_b = '1;
      end
      S_SUB: begin
        alu_b   = base_r;
        alu_sub = 1'b1;
      end
      S_PRE: begin
        alu_b   = stride_7;
        alu_sub = 1'b1;
      end
      S_DIV: begin
        alu_b   = stride_k;
        alu_sub = 1'b1;
      end
      S_MB: begin
        alu_a = base_r;
        alu_b = ADDR_W'(1);
      end
      S_ML: begin
        alu_b = sel_idx_r[k_r] ? stride_k : '0;
      end
      default: begin
        alu_b = '0;
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    rem_nxt        = rem_r;
    sel_idx_nxt    = sel_idx_r;
    scan_nxt       = scan_r;
    chk_idx_nxt    = chk_idx_r;
    chk_vld_nxt    = chk_vld_r;
    k_nxt          = k_r;
    mode_nxt       = mode_r;
    res_status_nxt = res_status_r;
    addr_en_nxt    = addr_en_r;
    count_nxt      = count_r;
    clr_nxt        = clr_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_sidx_nxt   = out_sidx_r;
    out_addr_nxt   = out_addr_r;
    mem_we         = 1'b0;
    mem_wa         = IW'(sel_idx_r);
    mem_wd         = 1'b0;
    rd_addr        = IW'((state_r == S_SCAN) ? scan_r : sel_idx_r);

    // The receiver took the pending result.
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLR: begin
        mem_we  = 1'b1;
        mem_wa  = clr_r;
        clr_nxt = clr_r + IW'(1);
        if (clr_r == IW'(MAX_SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          mode_nxt    = in_tuser;
          rem_nxt     = in_tdata[ADDR_W-1:0];
          sel_idx_nxt = {1'b0, in_tdata[ADDR_W+INDEX_W-1:ADDR_W]};
          addr_en_nxt = 1'b0;
          scan_nxt    = '0;
          chk_vld_nxt = 1'b0;
          case (in_tuser)
            MODE_ALLOC:     state_nxt = S_SCAN;
            MODE_FREE_ADDR: state_nxt = S_DEC;
            default:        state_nxt = S_IDX;
          endcase
        end
      end
      // Header address is the element address minus one.
      S_DEC: begin
        if (rem_r == '0) begin
          res_status_nxt = ST_RANGE;
          state_nxt      = S_OUT;
        end else begin
          rem_nxt   = alu_res;
          state_nxt = S_SUB;
        end
      end
      // Offset from the pool base; below the base is out of range.
      S_SUB: begin
        if (!alu_carry) begin
          res_status_nxt = ST_RANGE;
          state_nxt      = S_OUT;
        end else begin
          rem_nxt   = alu_res;
          state_nxt = S_PRE;
        end
      end
      // A quotient of 128 or more is beyond any slot count.
      S_PRE: begin
        if (alu_carry) begin
          res_status_nxt = ST_RANGE;
          state_nxt      = S_OUT;
        end else begin
          sel_idx_nxt = '0;
          k_nxt       = 3'd6;
          state_nxt   = S_DIV;
        end
      end
      // Restoring division by the stride, one quotient bit per cycle.
      S_DIV: begin
        if (alu_carry) begin
          rem_nxt          = alu_res;
          sel_idx_nxt[k_r] = 1'b1;
        end
        if (k_r == 3'd0) begin
          state_nxt = S_FCHK;
        end else begin
          k_nxt = k_r - 3'd1;
        end
      end
      // Range by quotient, then alignment by remainder; reads the mark.
      S_FCHK: begin
        if (sel_idx_r >= n_eff) begin
          res_status_nxt = ST_RANGE;
          state_nxt      = S_OUT;
        end else if (rem_r != '0) begin
          res_status_nxt = ST_MISALIGNED;
          state_nxt      = S_OUT;
        end else begin
          state_nxt = S_LOOK;
        end
      end
      // Index bound for free and get by index; reads the mark.
      S_IDX: begin
        if (sel_idx_r >= n_eff) begin
          res_status_nxt = ST_RANGE;
          state_nxt      = S_OUT;
        end else begin
          state_nxt = S_LOOK;
        end
      end
      // Mark read back: release the slot, or check it for a get.
      S_LOOK: begin
        if (mode_r == MODE_GET_IDX) begin
          if (rd_data_r) begin
            state_nxt = S_MB;
          end else begin
            res_status_nxt = ST_NOT_ALLOC;
            state_nxt      = S_OUT;
          end
        end else begin
          if (rd_data_r) begin
            mem_we    = 1'b1;
            mem_wd    = 1'b0;
            count_nxt = count_r - CNT_W'(1);
          end
          res_status_nxt = ST_OK;
          state_nxt      = S_OUT;
        end
      end
      // Lowest free slot search: one read issued and one checked a cycle.
      S_SCAN: begin
        if (chk_vld_r && !rd_data_r) begin
          mem_we      = 1'b1;
          mem_wa      = IW'(chk_idx_r);
          mem_wd      = 1'b1;
          count_nxt   = count_r + CNT_W'(1);
          sel_idx_nxt = chk_idx_r;
          state_nxt   = S_MB;
        end else if (scan_r < n_eff) begin
          chk_idx_nxt = scan_r;
          chk_vld_nxt = 1'b1;
          scan_nxt    = scan_r + COUNT_W'(1);
        end else begin
          res_status_nxt = ST_FULL;
          state_nxt      = S_OUT;
        end
      end
      // Element address: base plus one, then stride times index by shift-add.
      S_MB: begin
        rem_nxt        = alu_res;
        k_nxt          = 3'd0;
        addr_en_nxt    = 1'b1;
        res_status_nxt = ST_OK;
        state_nxt      = S_ML;
      end
      S_ML: begin
        rem_nxt = alu_res;
        if (k_r == 3'(COUNT_W - 1)) begin
          state_nxt = S_OUT;
        end else begin
          k_nxt = k_r + 3'd1;
        end
      end
      // Hand the result over once the output register is free.
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_sidx_nxt   = (res_status_r == ST_OK) ? sel_idx_r[INDEX_W-1:0] : '0;
          out_addr_nxt   = (res_status_r == ST_OK && addr_en_r) ? rem_r : '0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      chk_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      chk_vld_r   <= chk_vld_nxt;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= '0;
      elem_r   <= ELEM_W'(1);
      scount_r <= COUNT_W'(64);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BASE_ADDRESS:  base_r   <= cfg_wdata[ADDR_W-1:0];
        REG_ELEMENT_BYTES: elem_r   <= cfg_wdata[ELEM_W-1:0];
        REG_SLOT_COUNT:    scount_r <= cfg_wdata[COUNT_W-1:0];
        default: begin
          base_r <= base_r;
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    rem_r        <= rem_nxt;
    sel_idx_r    <= sel_idx_nxt;
    scan_r       <= scan_nxt;
    chk_idx_r    <= chk_idx_nxt;
    k_r          <= k_nxt;
    mode_r       <= mode_nxt;
    res_status_r <= res_status_nxt;
    addr_en_r    <= addr_en_nxt;
    out_status_r <= out_status_nxt;
    out_sidx_r   <= out_sidx_nxt;
    out_addr_r   <= out_addr_nxt;
  end

  // In-use memory: one write and one registered read a cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule

// File: verif/fixed_slot_pool_allocator_test.sv
`timescale 1ns / 100ps

module fixed_slot_pool_allocator_test;

  import fspa_pkg::*;

  // One request beat as the sender sees it.
  typedef struct packed {
    mode_t                      mode;
    logic [ADDR_W-1:0]          element_address;
    logic [INDEX_W-1:0]         slot_index;
  } pool_request_t;

  // One result beat as the receiver sees it.
  typedef struct packed {
    status_t                    status;
    logic [INDEX_W-1:0]         slot_index;
    logic [ADDR_W-1:0]          slot_address;
  } pool_result_t;

  // Shadow of the slot pool: tracks the in-use marks and the register values,
  // works out the result of every accepted request and holds those results
  // until the matching beats leave the block.
  class slot_pool_model #(int SLOTS = 64);
    logic [ADDR_W-1:0]  base_address  = '0;
    logic [ELEM_W-1:0]  element_bytes = 16'd1;
    logic [COUNT_W-1:0] slot_count    = 7'd64;
    bit                 in_use [SLOTS];
    pool_result_t       awaited_results [$];
    int unsigned        results_checked;
    int unsigned        mismatches;
    int unsigned        status_tally [5];

    function void configure(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
      case (index)
        REG_BASE_ADDRESS:  base_address  = value[ADDR_W-1:0];
        REG_ELEMENT_BYTES: element_bytes = value[ELEM_W-1:0];
        REG_SLOT_COUNT:    slot_count    = value[COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    // A count above the pool size behaves as the pool size.
    function logic [63:0] live_slots();
      return (slot_count > SLOTS) ? 64'(SLOTS) : 64'(slot_count);
    endfunction

    // Element address of a slot: one byte past its header, wrapping.
    function logic [ADDR_W-1:0] element_at(int slot);
      logic [63:0] stride;
      logic [63:0] addr;
      stride = 64'(element_bytes) + 64'd1;
      addr   = 64'(base_address) + stride * 64'(slot) + 64'd1;
      return addr[ADDR_W-1:0];
    endfunction

    function pool_result_t serve_request(pool_request_t r);
      logic [63:0]  n;
      logic [63:0]  stride;
      logic [63:0]  header;
      logic [63:0]  offset;
      int           slot;
      bit           found;
      pool_result_t res;
      n      = live_slots();
      stride = 64'(element_bytes) + 64'd1;
      res    = '{status: ST_OK, slot_index: '0, slot_address: '0};
      found  = 1'b0;
      case (r.mode)
        // The lowest free slot below the live count wins.
        MODE_ALLOC: begin
          res.status = ST_FULL;
          for (int i = 0; i < SLOTS; i++) begin
            if (!found && 64'(i) < n && !in_use[i]) begin
              in_use[i]        = 1'b1;
              found            = 1'b1;
              res.status       = ST_OK;
              res.slot_index   = INDEX_W'(i);
              res.slot_address = element_at(i);
            end
          end
        end
        // The header must lie inside the pool, without wrap, on a slot boundary.
        MODE_FREE_ADDR: begin
          header = 64'(r.element_address) - 64'd1;
          if (r.element_address == '0 || header < 64'(base_address) ||
              header - 64'(base_address) >= stride * n) begin
            res.status = ST_RANGE;
          end else begin
            offset = header - 64'(base_address);
            if (offset % stride != 0) begin
              res.status = ST_MISALIGNED;
            end else begin
              slot           = int'(offset / stride);
              in_use[slot]   = 1'b0;
              res.slot_index = INDEX_W'(slot);
            end
          end
        end
        default: begin
          slot = int'(r.slot_index);
          if (64'(r.slot_index) >= n) begin
            res.status = ST_RANGE;
          end else if (r.mode == MODE_FREE_IDX) begin
            in_use[slot]   = 1'b0;
            res.slot_index = r.slot_index;
          end else if (!in_use[slot]) begin
            res.status = ST_NOT_ALLOC;
          end else begin
            res.slot_index   = r.slot_index;
            res.slot_address = element_at(slot);
          end
        end
      endcase
      return res;
    endfunction

    function void note_request(pool_request_t r);
      pool_result_t res;
      res = serve_request(r);
      status_tally[res.status]++;
      awaited_results.push_back(res);
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= 50) $display("MISMATCH: %s", what);
    endtask

    task check_result(pool_result_t got);
      pool_result_t want;
      results_checked++;
      if (awaited_results.size() == 0) begin
        report($sformatf("result %0d arrived with nothing outstanding (status %0d)",
                         results_checked, got.status));
        return;
      end
      want = awaited_results.pop_front();
      if (got.status !== want.status)
        report($sformatf("result %0d status: got %0d, expected %0d",
                         results_checked, got.status, want.status));
      if (got.slot_index !== want.slot_index)
        report($sformatf("result %0d slot_index: got %0d, expected %0d",
                         results_checked, got.slot_index, want.slot_index));
      if (got.slot_address !== want.slot_address)
        report($sformatf("result %0d slot_address: got %h, expected %h",
                         results_checked, got.slot_address, want.slot_address));
    endtask
  endclass

  localparam int POOL_SLOTS       = 64;
  localparam int PHASES           = 8;
  localparam int RANDOM_PER_PHASE = 200;
  localparam int IDLE_PCT         = 14;
  localparam int HOLD_CYCLES      = 400;
  localparam int HOLD_AFTER       = 400;
  localparam int DRAIN_CYCLES     = 100;
  localparam int STALL_LIMIT      = 3000;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    in_tvalid;
  logic                    in_tready;
  logic [IN_TDATA_W-1:0]   in_tdata;
  logic [IN_TUSER_W-1:0]   in_tuser;
  logic                    out_tvalid;
  logic                    out_tready;
  logic [OUT_TDATA_W-1:0]  out_tdata;
  logic [OUT_TUSER_W-1:0]  out_tuser;
  logic                    cfg_we;
  logic [CFG_INDEX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_wdata;

  slot_pool_model #(POOL_SLOTS) pool;
  bit                           steady;
  int                           requests_sent;
  int                           directed_sent;
  int                           quiet_cycles;

  fixed_slot_pool_allocator #(.MAX_SLOTS(POOL_SLOTS)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one request beat and wait until the block takes it. The valid stays
  // high afterwards so that back-to-back beats need no second assignment.
  task automatic send_request(pool_request_t r);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'({r.slot_index, r.element_address});
    in_tuser  <= r.mode;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pool.note_request(r);
    requests_sent++;
  endtask

  task automatic send_directed(mode_t mode, logic [ADDR_W-1:0] addr,
                               logic [INDEX_W-1:0] index);
    send_request('{mode: mode, element_address: addr, slot_index: index});
    directed_sent++;
  endtask

  // Stop offering and wait until every outstanding result has left the block.
  task automatic finish_burst();
    in_tvalid <= 1'b0;
    while (pool.awaited_results.size() != 0) @(posedge clk);
  endtask

  // Write all three registers on consecutive edges; only called while idle.
  task automatic program_pool(logic [ADDR_W-1:0] base, logic [ELEM_W-1:0] elem,
                              logic [COUNT_W-1:0] count);
    logic [CFG_INDEX_W-1:0] regs   [3];
    logic [CFG_DATA_W-1:0]  values [3];
    regs   = '{REG_BASE_ADDRESS, REG_ELEMENT_BYTES, REG_SLOT_COUNT};
    values = '{CFG_DATA_W'(base), CFG_DATA_W'(elem), CFG_DATA_W'(count)};
    for (int k = 0; k < 3; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[k];
      cfg_wdata <= values[k];
      @(posedge clk);
      pool.configure(regs[k], values[k]);
    end
    cfg_we <= 1'b0;
  endtask

  // Mostly well-formed requests: allocations, frees of real slot addresses
  // and in-range indexes. The rest are near misses and random addresses.
  function automatic pool_request_t pick_request(int alloc_pct);
    pool_request_t     r;
    logic [63:0]       live;
    logic [63:0]       stride;
    logic [ADDR_W-1:0] slot_addr;
    r.mode            = MODE_ALLOC;
    r.element_address = $urandom;
    r.slot_index      = INDEX_W'($urandom_range(63));
    live              = pool.live_slots();
    stride            = 64'(pool.element_bytes) + 64'd1;
    slot_addr         = r.element_address;
    if (live != 0)
      slot_addr = pool.element_at($urandom_range(int'(live) - 1));
    if ($urandom_range(99) < alloc_pct) return r;
    case ($urandom_range(19))
      0, 1, 2, 3, 4, 5, 6: begin
        r.mode            = MODE_FREE_ADDR;
        r.element_address = slot_addr;
      end
      7, 8, 9: begin
        r.mode = MODE_FREE_ADDR;
        case ($urandom_range(3))
          0: ;
          // Header one byte below the pool.
          1: r.element_address = pool.base_address;
          // First slot past the end of the pool.
          2: r.element_address = ADDR_W'(64'(pool.base_address) + stride * live + 64'd1);
          default: r.element_address = slot_addr +
                                       ADDR_W'($urandom_range(int'(stride) - 1));
        endcase
      end
      10, 11, 12, 13, 14: r.mode = MODE_FREE_IDX;
      default:            r.mode = MODE_GET_IDX;
    endcase
    if (r.mode != MODE_FREE_ADDR && live != 0 && $urandom_range(99) < 85)
      r.slot_index = INDEX_W'($urandom_range(int'(live) - 1));
    return r;
  endfunction

  // Result beats are checked as they leave.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_tvalid && out_tready)
      pool.check_result('{status: out_tuser, slot_index: out_tdata[INDEX_W-1:0],
                          slot_address: out_tdata[INDEX_W+ADDR_W-1:INDEX_W]});
  end

  // Receiver: random stalls, none during the steady phase, and one long
  // hold-off so that the block backs up and closes its input.
  initial begin
    bit held;
    held = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held && pool.results_checked >= HOLD_AFTER) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog: too long without any beat on either side ends the run.
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no beat accepted for %0d cycles", quiet_cycles);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [ADDR_W-1:0]  set_base  [PHASES];
    logic [ELEM_W-1:0]  set_elem  [PHASES];
    logic [COUNT_W-1:0] set_count [PHASES];
    int                 set_alloc [PHASES];
    pool = new();
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    steady        = 1'b0;
    requests_sent = 0;
    directed_sent = 0;

    // Pool settings per phase: defaults, a small pool, one that wraps the
    // address space, the extremes, header-only slots, a count above the
    // maximum, an empty pool and a random one.
    set_base  = '{32'h0, 32'h0000_1000, 32'hFFFF_FFF0, 32'hFFFF_FFFF,
                  32'h0, 32'h8000_0000, $urandom, $urandom};
    set_elem  = '{16'd1, 16'd15, 16'd3, 16'hFFFF, 16'd0, 16'd7, 16'd0,
                  16'($urandom_range(300, 1))};
    set_count = '{7'd64, 7'd8, 7'd64, 7'd1, 7'd64, 7'd100, 7'd0,
                  7'($urandom_range(64, 1))};
    set_alloc = '{50, 45, 60, 40, 55, 50, 30, 45};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Opening checks on the reset settings: base 0, stride 2, 64 slots.
    send_directed(MODE_GET_IDX,   32'h0,         6'd0);   // never allocated
    send_directed(MODE_FREE_IDX,  32'h0,         6'd0);   // freeing a free slot
    send_directed(MODE_ALLOC,     32'h0,         6'd0);
    send_directed(MODE_ALLOC,     32'h0,         6'd0);
    send_directed(MODE_GET_IDX,   32'h0,         6'd1);
    send_directed(MODE_GET_IDX,   32'hFFFF_FFFF, 6'd63);
    send_directed(MODE_FREE_ADDR, 32'h0,         6'd0);   // element address zero
    send_directed(MODE_FREE_ADDR, 32'h2,         6'd0);   // off the slot grid
    send_directed(MODE_FREE_ADDR, 32'hFFFF_FFFF, 6'd63);
    send_directed(MODE_FREE_ADDR, 32'd129,       6'd0);   // just past the pool
    send_directed(MODE_FREE_ADDR, 32'd127,       6'd0);   // last slot, free
    send_directed(MODE_FREE_ADDR, 32'd1,         6'd0);
    send_directed(MODE_FREE_IDX,  32'h0,         6'd1);
    send_directed(MODE_ALLOC,     32'hFFFF_FFFF, 6'd63);

    for (int phase = 0; phase < PHASES; phase++) begin
      finish_burst();
      program_pool(set_base[phase], set_elem[phase], set_count[phase]);
      steady = (phase == 4);
      case (phase)
        // One slot at the top of the address space: its element address
        // wraps to zero, and a second allocation finds the pool full.
        3: begin
          send_directed(MODE_ALLOC,     32'h0, 6'd0);
          send_directed(MODE_ALLOC,     32'h0, 6'd0);
          send_directed(MODE_GET_IDX,   32'h0, 6'd1);
          send_directed(MODE_FREE_IDX,  32'h0, 6'd63);
          send_directed(MODE_GET_IDX,   32'h0, 6'd0);
          send_directed(MODE_FREE_ADDR, 32'h0, 6'd0);
          send_directed(MODE_FREE_IDX,  32'h0, 6'd0);
        end
        // Empty pool.
        6: begin
          send_directed(MODE_ALLOC,   32'h0, 6'd0);
          send_directed(MODE_GET_IDX, 32'h0, 6'd0);
        end
        default: ;
      endcase
      for (int k = 0; k < RANDOM_PER_PHASE; k++)
        send_request(pick_request(set_alloc[phase]));
    end

    finish_burst();
    steady = 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pool.awaited_results.size() != 0)
      pool.report($sformatf("%0d results never arrived", pool.awaited_results.size()));

    $display("Sent %0d requests (%0d directed) over %0d pool settings; checked %0d results.",
             requests_sent, directed_sent, PHASES, pool.results_checked);
    $display("Expected statuses: ok %0d, full %0d, out of range %0d, misaligned %0d, %s %0d.",
             pool.status_tally[ST_OK], pool.status_tally[ST_FULL],
             pool.status_tally[ST_RANGE], pool.status_tally[ST_MISALIGNED],
             "not allocated", pool.status_tally[ST_NOT_ALLOC]);
    if (pool.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
